>>> rtl/brb_pkg.sv
`default_nettype none

package brb_pkg;

    // default sizes handed to the top level
    localparam int DEPTH_DEF    = 256;
    localparam int MAX_READ_DEF = 32;

    // field widths
    localparam int MODE_W = 3;
    localparam int DATA_W = 8;
    localparam int BLEN_W = 9;
    localparam int RC_W   = 6;
    localparam int SIZE_W = 9;
    localparam int FILL_W = 8;

    // mode codes on the input channel
    localparam logic [MODE_W-1:0] MODE_PUT    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_COMMIT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_GET    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PEEK   = 3'd3;

    // classified operation
    typedef enum logic [2:0] {
        OP_PUT,
        OP_COMMIT,
        OP_GET,
        OP_PEEK,
        OP_STATUS
    } t_op;

    // one queued command from front to back
    typedef struct packed {
        t_op               op;
        logic [DATA_W-1:0] data;
        logic              first;
        logic [BLEN_W-1:0] blen;
        logic [RC_W-1:0]   rcount;
    } t_cmd;

    // back end sequencer
    typedef enum logic [1:0] {
        S_IDLE,
        S_ADDR,
        S_DATA
    } t_state;

endpackage

`default_nettype wire

>>> rtl/byte_ring_buffer_with_commit_core.sv
// Byte ring buffer with a staged write pointer and a commit step.
// Input channel (i_valid / o_stall): one command per transfer, selected by
// i_mode: put byte, commit, get, peek or status (unused codes act as status).
// Output channel (o_valid / i_stall): result transfers; o_last marks the final
// result of a command. Get and peek give one result per byte read, or one if
// no byte can be read; all other commands give exactly one.
// Config: i_cfg_wr_en writes the ring size and restarts all pointers.
// Result path: a put, commit, status or empty read result passes the command
// queue and the output register. A get or peek passes the command queue, then
// each byte passes an address state, then a data state (the byte store has a
// registered read port), then the output register.
// Throughput: put, commit and status run at one command per cycle while the
// receiver does not stall; a get or peek holds the execution side until done.
// A two-entry command queue sits between intake and execution; a stalled
// receiver fills the output register, then the queue, then raises o_stall.
// Reset clears the pointers and the drop flag and sets the ring size to its
// largest value; the store itself is not cleared and needs no clearing pass.
`default_nettype none

module byte_ring_buffer_with_commit_core #(
    parameter int DEPTH    = brb_pkg::DEPTH_DEF,
    parameter int MAX_READ = brb_pkg::MAX_READ_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [brb_pkg::SIZE_W-1:0]  i_cfg_wr_data,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [brb_pkg::MODE_W-1:0]  i_mode,
    input  wire logic [brb_pkg::DATA_W-1:0]  i_data_in,
    input  wire logic                        i_first_of_block,
    input  wire logic [brb_pkg::BLEN_W-1:0]  i_block_length,
    input  wire logic [brb_pkg::RC_W-1:0]    i_read_count,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [brb_pkg::DATA_W-1:0]       o_data_out,
    output logic                             o_data_valid,
    output logic                             o_last,
    output logic                             o_accepted,
    output logic [brb_pkg::FILL_W-1:0]       o_fill_level,
    output logic [brb_pkg::SIZE_W-1:0]       o_free_space
);

    import brb_pkg::*;

    t_cmd cmd;
    logic cmd_valid;
    logic cmd_pop;

    // intake and classification
    brb_front #(
        .MAX_READ (MAX_READ)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_mode           (i_mode),
        .i_data_in        (i_data_in),
        .i_first_of_block (i_first_of_block),
        .i_block_length   (i_block_length),
        .i_read_count     (i_read_count),
        .o_cmd            (cmd),
        .o_cmd_valid      (cmd_valid),
        .i_cmd_pop        (cmd_pop)
    );

    // execution against the ring
    brb_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (cmd),
        .i_cmd_valid   (cmd_valid),
        .o_cmd_pop     (cmd_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_data_out    (o_data_out),
        .o_data_valid  (o_data_valid),
        .o_last        (o_last),
        .o_accepted    (o_accepted),
        .o_fill_level  (o_fill_level),
        .o_free_space  (o_free_space)
    );

endmodule

`default_nettype wire

>>> rtl/brb_ram.sv
`default_nettype none

module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/brb_front.sv
`default_nettype none

module brb_front #(
    parameter int MAX_READ = brb_pkg::MAX_READ_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [brb_pkg::MODE_W-1:0]  i_mode,
    input  wire logic [brb_pkg::DATA_W-1:0]  i_data_in,
    input  wire logic                        i_first_of_block,
    input  wire logic [brb_pkg::BLEN_W-1:0]  i_block_length,
    input  wire logic [brb_pkg::RC_W-1:0]    i_read_count,
    output brb_pkg::t_cmd                    o_cmd,
    output logic                             o_cmd_valid,
    input  wire logic                        i_cmd_pop
);

    import brb_pkg::*;

    localparam int QD = 2;

    t_cmd              r_q [QD];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;
    t_cmd              cmd_in;
    logic              push;
    logic              pop;

    // classify mode and clip the read count
    always_comb begin
        cmd_in.data   = i_data_in;
        cmd_in.first  = i_first_of_block;
        cmd_in.blen   = i_block_length;
        if ((RC_W + 1)'(i_read_count) > (RC_W + 1)'(MAX_READ)) begin
            cmd_in.rcount = RC_W'(MAX_READ);
        end else begin
            cmd_in.rcount = i_read_count;
        end
        unique case (i_mode)
            MODE_PUT:    cmd_in.op = OP_PUT;
            MODE_COMMIT: cmd_in.op = OP_COMMIT;
            MODE_GET:    cmd_in.op = OP_GET;
            MODE_PEEK:   cmd_in.op = OP_PEEK;
            default:     cmd_in.op = OP_STATUS;
        endcase
    end

    assign o_stall     = (r_cnt == 2'(QD));
    assign push        = i_valid && !o_stall;
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    // queue pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // queue entries
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

>>> rtl/brb_back.sv
`default_nettype none

module brb_back #(
    parameter int DEPTH = brb_pkg::DEPTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [brb_pkg::SIZE_W-1:0]  i_cfg_wr_data,
    input  brb_pkg::t_cmd                    i_cmd,
    input  wire logic                        i_cmd_valid,
    output logic                             o_cmd_pop,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [brb_pkg::DATA_W-1:0]       o_data_out,
    output logic                             o_data_valid,
    output logic                             o_last,
    output logic                             o_accepted,
    output logic [brb_pkg::FILL_W-1:0]       o_fill_level,
    output logic [brb_pkg::SIZE_W-1:0]       o_free_space
);

    import brb_pkg::*;

    localparam int CAP = (DEPTH < 256) ? DEPTH : 256;
    localparam int PW  = $clog2(CAP);
    localparam logic [SIZE_W-1:0] CAP_S = SIZE_W'(CAP);
    localparam logic [SIZE_W-1:0] MIN_S = SIZE_W'(2);

    t_state            r_state, n_state;
    logic [PW-1:0]     r_rd, n_rd;
    logic [PW-1:0]     r_cm, n_cm;
    logic [PW-1:0]     r_st, n_st;
    logic              r_drop, n_drop;
    logic [SIZE_W-1:0] r_size;
    logic [PW-1:0]     r_p, n_p;
    logic [RC_W-1:0]   r_cnt, n_cnt;
    logic              r_is_get, n_is_get;
    logic [FILL_W-1:0] r_fill_out, n_fill_out;

    logic              r_ov;
    logic [DATA_W-1:0] r_dout;
    logic              r_dv;
    logic              r_last;
    logic              r_acc;
    logic [FILL_W-1:0] r_fill;
    logic [SIZE_W-1:0] r_free;

    logic [FILL_W-1:0] fill_cur;
    logic [FILL_W-1:0] fill_cmt;
    logic [SIZE_W-1:0] free_cur;
    logic              drop_now;
    logic [RC_W-1:0]   rd_len;
    logic              out_ready;
    logic              emit;
    logic [DATA_W-1:0] e_dout;
    logic              e_dv;
    logic              e_last;
    logic              e_acc;
    logic [FILL_W-1:0] e_fill;
    logic [SIZE_W-1:0] e_free;
    logic              ram_we;
    logic [DATA_W-1:0] ram_rdata;

    // next pointer position with wrap at the ring size
    function automatic logic [PW-1:0] adv(input logic [PW-1:0] p,
                                          input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] q;
        q = SIZE_W'(p) + SIZE_W'(1);
        return (q >= s) ? '0 : q[PW-1:0];
    endfunction

    // bytes between read and write pointer
    function automatic logic [FILL_W-1:0] fill_of(input logic [PW-1:0] r,
                                                  input logic [PW-1:0] c,
                                                  input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] d;
        if (c >= r) begin
            d = SIZE_W'(c) - SIZE_W'(r);
        end else begin
            d = s + SIZE_W'(c) - SIZE_W'(r);
        end
        return d[FILL_W-1:0];
    endfunction

    assign fill_cur  = fill_of(r_rd, r_cm, r_size);
    assign fill_cmt  = fill_of(r_rd, r_st, r_size);
    assign free_cur  = r_size - SIZE_W'(fill_cur);
    assign drop_now  = i_cmd.first ? (free_cur <= i_cmd.blen) : r_drop;
    assign rd_len    = (FILL_W'(i_cmd.rcount) < fill_cur) ? i_cmd.rcount
                                                           : RC_W'(fill_cur);
    assign out_ready = !r_ov || !i_stall;

    // byte store
    brb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAP)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_st),
        .i_wdata (i_cmd.data),
        .i_raddr (r_p),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && (i_cmd.op == OP_GET || i_cmd.op == OP_PEEK)
                    && rd_len != '0) begin
                    n_state = S_ADDR;
                end
            end
            S_ADDR: n_state = S_DATA;
            S_DATA: begin
                if (out_ready) begin
                    n_state = (r_cnt == RC_W'(1)) ? S_IDLE : S_ADDR;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // command execution and result build
    always_comb begin
        o_cmd_pop  = 1'b0;
        emit       = 1'b0;
        ram_we     = 1'b0;
        e_dout     = '0;
        e_dv       = 1'b0;
        e_last     = 1'b1;
        e_acc      = 1'b0;
        e_fill     = fill_cur;
        n_rd       = r_rd;
        n_cm       = r_cm;
        n_st       = r_st;
        n_drop     = r_drop;
        n_p        = r_p;
        n_cnt      = r_cnt;
        n_is_get   = r_is_get;
        n_fill_out = r_fill_out;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.op) inside
                        OP_PUT: begin
                            if (out_ready) begin
                                o_cmd_pop = 1'b1;
                                emit      = 1'b1;
                                n_drop    = drop_now;
                                if (!drop_now) begin
                                    ram_we = 1'b1;
                                    n_st   = adv(r_st, r_size);
                                    e_acc  = 1'b1;
                                end
                            end
                        end
                        OP_COMMIT: begin
                            if (out_ready) begin
                                o_cmd_pop = 1'b1;
                                emit      = 1'b1;
                                n_cm      = r_st;
                                e_fill    = fill_cmt;
                            end
                        end
                        OP_GET, OP_PEEK: begin
                            if (rd_len == '0) begin
                                if (out_ready) begin
                                    o_cmd_pop = 1'b1;
                                    emit      = 1'b1;
                                end
                            end else begin
                                o_cmd_pop = 1'b1;
                                n_p       = r_rd;
                                n_cnt     = rd_len;
                                n_is_get  = (i_cmd.op == OP_GET);
                                n_fill_out = (i_cmd.op == OP_GET)
                                           ? fill_cur - FILL_W'(rd_len) : fill_cur;
                            end
                        end
                        OP_STATUS: begin
                            if (out_ready) begin
                                o_cmd_pop = 1'b1;
                                emit      = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_ADDR: begin
                // store read in flight
            end
            S_DATA: begin
                if (out_ready) begin
                    emit   = 1'b1;
                    e_dout = ram_rdata;
                    e_dv   = 1'b1;
                    e_last = (r_cnt == RC_W'(1));
                    e_fill = r_fill_out;
                    n_p    = adv(r_p, r_size);
                    n_cnt  = r_cnt - RC_W'(1);
                    if (r_cnt == RC_W'(1) && r_is_get) begin
                        n_rd = adv(r_p, r_size);
                    end
                end
            end
            default: begin
            end
        endcase
        e_free = r_size - SIZE_W'(e_fill);
    end

    // control state; a size write restarts the ring
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rd    <= '0;
            r_cm    <= '0;
            r_st    <= '0;
            r_drop  <= 1'b0;
            r_size  <= CAP_S;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                r_rd   <= '0;
                r_cm   <= '0;
                r_st   <= '0;
                r_drop <= 1'b0;
                if (i_cfg_wr_data < MIN_S) begin
                    r_size <= MIN_S;
                end else if (i_cfg_wr_data > CAP_S) begin
                    r_size <= CAP_S;
                end else begin
                    r_size <= i_cfg_wr_data;
                end
            end else begin
                r_rd   <= n_rd;
                r_cm   <= n_cm;
                r_st   <= n_st;
                r_drop <= n_drop;
            end
        end
    end

    // read sequencing and output payload
    always_ff @(posedge i_clk) begin
        r_p        <= n_p;
        r_cnt      <= n_cnt;
        r_is_get   <= n_is_get;
        r_fill_out <= n_fill_out;
        if (emit) begin
            r_dout <= e_dout;
            r_dv   <= e_dv;
            r_last <= e_last;
            r_acc  <= e_acc;
            r_fill <= e_fill;
            r_free <= e_free;
        end
    end

    assign o_valid      = r_ov;
    assign o_data_out   = r_dout;
    assign o_data_valid = r_dv;
    assign o_last       = r_last;
    assign o_accepted   = r_acc;
    assign o_fill_level = r_fill;
    assign o_free_space = r_free;

endmodule

`default_nettype wire

>>> tb/brb_ring_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the ring size port, tracks the ring contents and
// pointers, and compares every result transfer with the next predicted one.
module brb_ring_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [brb_pkg::SIZE_W-1:0]  i_cfg_wr_data,
    input  wire logic                        i_cmd_valid,
    input  wire logic                        i_cmd_stall,
    input  wire logic [brb_pkg::MODE_W-1:0]  i_mode,
    input  wire logic [brb_pkg::DATA_W-1:0]  i_data_in,
    input  wire logic                        i_first_of_block,
    input  wire logic [brb_pkg::BLEN_W-1:0]  i_block_length,
    input  wire logic [brb_pkg::RC_W-1:0]    i_read_count,
    input  wire logic                        i_res_valid,
    input  wire logic                        i_res_stall,
    input  wire logic [brb_pkg::DATA_W-1:0]  i_data_out,
    input  wire logic                        i_data_valid,
    input  wire logic                        i_last,
    input  wire logic                        i_accepted,
    input  wire logic [brb_pkg::FILL_W-1:0]  i_fill_level,
    input  wire logic [brb_pkg::SIZE_W-1:0]  i_free_space,
    output int                               o_fail_count,
    output int                               o_replies_due
);

    import brb_pkg::*;

    localparam int STORE_BYTES = DEPTH_DEF;
    localparam int SIZE_CAP    = (DEPTH_DEF < 256) ? DEPTH_DEF : 256;
    localparam int READ_CAP    = MAX_READ_DEF;
    localparam int PRINT_CAP   = 200;

    // one result transfer as the block should present it
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              data_valid;
        logic              last;
        logic              accepted;
        logic [FILL_W-1:0] fill;
        logic [SIZE_W-1:0] free;
    } ring_reply_t;

    logic [DATA_W-1:0] ring_mem [STORE_BYTES];
    int                rd_ptr;
    int                cw_ptr;
    int                sw_ptr;
    bit                drop_open;
    int                size_reg;
    ring_reply_t       ring_replies [$];
    ring_reply_t       reply;

    initial begin
        o_fail_count  = 0;
        o_replies_due = 0;
    end

    // ring size as used: clamped to the legal span
    function automatic int live_size();
        int s;
        s = size_reg;
        if (s < 2) s = 2;
        if (s > SIZE_CAP) s = SIZE_CAP;
        return s;
    endfunction

    function automatic int next_slot(int p, int size);
        return (p + 1 >= size) ? 0 : p + 1;
    endfunction

    // committed bytes between read and committed write pointer
    function automatic int committed_fill(int size);
        return (cw_ptr >= rd_ptr) ? cw_ptr - rd_ptr : size + cw_ptr - rd_ptr;
    endfunction

    task automatic push_reply(int data, bit dv, bit lst, bit acc, int size);
        ring_reply_t r;
        int          fill;
        fill         = committed_fill(size);
        r.data       = DATA_W'(data);
        r.data_valid = dv;
        r.last       = lst;
        r.accepted   = acc;
        r.fill       = FILL_W'(fill);
        r.free       = SIZE_W'(size - fill);
        ring_replies.push_back(r);
    endtask

    // advance the ring state by one command and queue its results
    task automatic apply_ring_cmd(
        input logic [MODE_W-1:0] mode,
        input logic [DATA_W-1:0] din,
        input logic              first,
        input logic [BLEN_W-1:0] blen,
        input logic [RC_W-1:0]   rcount
    );
        int                size;
        int                want;
        int                n;
        int                p;
        bit                acc;
        logic [DATA_W-1:0] got [READ_CAP];
        size = live_size();
        acc  = 1'b0;
        case (mode)
            MODE_PUT: begin
                // space check only on the first byte; staged bytes not counted
                if (first) drop_open = (size - committed_fill(size)) <= int'(blen);
                if (!drop_open) begin
                    ring_mem[sw_ptr] = din;
                    sw_ptr = next_slot(sw_ptr, size);
                    acc = 1'b1;
                end
                push_reply(0, 1'b0, 1'b1, acc, size);
            end
            MODE_COMMIT: begin
                cw_ptr = sw_ptr;
                push_reply(0, 1'b0, 1'b1, 1'b0, size);
            end
            MODE_GET, MODE_PEEK: begin
                want = (int'(rcount) > READ_CAP) ? READ_CAP : int'(rcount);
                n = 0;
                p = rd_ptr;
                while (n < want && p != cw_ptr) begin
                    got[n] = ring_mem[p];
                    n++;
                    p = next_slot(p, size);
                end
                if (mode == MODE_GET) rd_ptr = p;
                if (n == 0) begin
                    push_reply(0, 1'b0, 1'b1, 1'b0, size);
                end else begin
                    for (int i = 0; i < n; i++)
                        push_reply(int'(got[i]), 1'b1, i == n - 1, 1'b0, size);
                end
            end
            // status and the unused codes only report
            default: push_reply(0, 1'b0, 1'b1, 1'b0, size);
        endcase
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            o_fail_count++;
            if (o_fail_count <= PRINT_CAP)
                $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // config first, then the command taken, then the result presented
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rd_ptr    = 0;
            cw_ptr    = 0;
            sw_ptr    = 0;
            drop_open = 1'b0;
            size_reg  = SIZE_CAP;
            ring_replies.delete();
        end else begin
            if (i_cfg_wr_en) begin
                size_reg  = int'(i_cfg_wr_data);
                rd_ptr    = 0;
                cw_ptr    = 0;
                sw_ptr    = 0;
                drop_open = 1'b0;
            end
            if (i_cmd_valid && !i_cmd_stall)
                apply_ring_cmd(i_mode, i_data_in, i_first_of_block, i_block_length,
                               i_read_count);
            if (i_res_valid && !i_res_stall) begin
                if (ring_replies.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= PRINT_CAP)
                        $display("%0t ns: result transfer with none pending, expected none, got data_out %0d last %0b",
                                 $time, i_data_out, i_last);
                end else begin
                    reply = ring_replies.pop_front();
                    check_field("data_out",   16'(reply.data),       16'(i_data_out));
                    check_field("data_valid", 16'(reply.data_valid), 16'(i_data_valid));
                    check_field("last",       16'(reply.last),       16'(i_last));
                    check_field("accepted",   16'(reply.accepted),   16'(i_accepted));
                    check_field("fill_level", 16'(reply.fill),       16'(i_fill_level));
                    check_field("free_space", 16'(reply.free),       16'(i_free_space));
                end
            end
        end
        o_replies_due = ring_replies.size();
    end

endmodule

>>> tb/byte_ring_buffer_with_commit_core_test.sv
`timescale 1ns / 1ps

module byte_ring_buffer_with_commit_core_test;

    import brb_pkg::*;

    localparam logic [MODE_W-1:0] MODE_STATUS = 3'd4;
    localparam logic [MODE_W-1:0] MODE_LAST   = 3'd7;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PARK_CYCLES = 120;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_wr_en;
    logic [SIZE_W-1:0] i_cfg_wr_data;
    logic              i_valid;
    wire               o_stall;
    logic [MODE_W-1:0] i_mode;
    logic [DATA_W-1:0] i_data_in;
    logic              i_first_of_block;
    logic [BLEN_W-1:0] i_block_length;
    logic [RC_W-1:0]   i_read_count;
    wire               o_valid;
    logic              i_stall;
    wire [DATA_W-1:0]  o_data_out;
    wire               o_data_valid;
    wire               o_last;
    wire               o_accepted;
    wire [FILL_W-1:0]  o_fill_level;
    wire [SIZE_W-1:0]  o_free_space;

    int fail_count;
    int replies_due;
    int gap_pct;
    bit park_request;
    int ring_span;
    int cycle_count;
    int phase_sizes [10];

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    byte_ring_buffer_with_commit_core i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_mode           (i_mode),
        .i_data_in        (i_data_in),
        .i_first_of_block (i_first_of_block),
        .i_block_length   (i_block_length),
        .i_read_count     (i_read_count),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_data_out       (o_data_out),
        .o_data_valid     (o_data_valid),
        .o_last           (o_last),
        .o_accepted       (o_accepted),
        .o_fill_level     (o_fill_level),
        .o_free_space     (o_free_space)
    );

    brb_ring_checker i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_cmd_valid      (i_valid),
        .i_cmd_stall      (o_stall),
        .i_mode           (i_mode),
        .i_data_in        (i_data_in),
        .i_first_of_block (i_first_of_block),
        .i_block_length   (i_block_length),
        .i_read_count     (i_read_count),
        .i_res_valid      (o_valid),
        .i_res_stall      (i_stall),
        .i_data_out       (o_data_out),
        .i_data_valid     (o_data_valid),
        .i_last           (o_last),
        .i_accepted       (o_accepted),
        .i_fill_level     (o_fill_level),
        .i_free_space     (o_free_space),
        .o_fail_count     (fail_count),
        .o_replies_due    (replies_due)
    );

    // one command transfer; optional idle burst ahead of it
    task automatic issue(
        input logic [MODE_W-1:0] mode,
        input logic [DATA_W-1:0] din,
        input logic              first,
        input logic [BLEN_W-1:0] blen,
        input logic [RC_W-1:0]   rcount
    );
        @(negedge i_clk);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        i_mode           <= mode;
        i_data_in        <= din;
        i_first_of_block <= first;
        i_block_length   <= blen;
        i_read_count     <= rcount;
        i_valid          <= 1'b1;
        do @(posedge i_clk); while (o_stall);
    endtask

    // put block: the length claim rides on the first byte only
    task automatic put_block(int len, int claim);
        for (int i = 0; i < len; i++)
            issue(MODE_PUT, DATA_W'($urandom_range(0, 255)), i == 0,
                  BLEN_W'((i == 0) ? claim : $urandom_range(0, 511)),
                  RC_W'($urandom_range(0, 63)));
    endtask

    // stop sending and wait until every result has come back
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (replies_due != 0) @(negedge i_clk);
    endtask

    task automatic set_ring_size(int value);
        drain();
        repeat (4) @(negedge i_clk);
        i_cfg_wr_data <= SIZE_W'(value);
        i_cfg_wr_en   <= 1'b1;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        ring_span = value;
        if (ring_span < 2) ring_span = 2;
        if (ring_span > 256) ring_span = 256;
    endtask

    // mostly well-formed blocks and reads, with stray bytes and odd codes
    task automatic run_random(int count);
        int done;
        int pick;
        int len;
        int claim;
        done = 0;
        while (done < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                len   = $urandom_range(1, 12);
                claim = $urandom_range(0, 19);
                if (claim < 10)      claim = len;
                else if (claim < 14) claim = 1;
                else if (claim < 17) claim = $urandom_range(0, 511);
                else                 claim = $urandom_range(1, ring_span);
                put_block(len, claim);
                done += len;
                if ($urandom_range(0, 4) != 0) begin
                    issue(MODE_COMMIT, DATA_W'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), BLEN_W'($urandom_range(0, 511)),
                          RC_W'($urandom_range(0, 63)));
                    done++;
                end
            end else if (pick < 75) begin
                issue($urandom_range(0, 1) ? MODE_GET : MODE_PEEK,
                      DATA_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      BLEN_W'($urandom_range(0, 511)),
                      RC_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                        : $urandom_range(1, 32)));
                done++;
            end else if (pick < 85) begin
                issue(MODE_W'($urandom_range(MODE_STATUS, MODE_LAST)),
                      DATA_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      BLEN_W'($urandom_range(0, 511)), RC_W'($urandom_range(0, 63)));
                done++;
            end else if (pick < 92) begin
                // byte with no block opened on it
                issue(MODE_PUT, DATA_W'($urandom_range(0, 255)), 1'b0,
                      BLEN_W'($urandom_range(0, 511)), RC_W'($urandom_range(0, 63)));
                done++;
            end else begin
                issue(MODE_COMMIT, DATA_W'($urandom_range(0, 255)), 1'b0,
                      BLEN_W'($urandom_range(0, 511)), RC_W'($urandom_range(0, 63)));
                done++;
            end
        end
    endtask

    // receiver: random stall bursts, and one long hold-off on request
    initial begin
        bit parked;
        parked  = 1'b0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (park_request && !parked) begin
                parked = 1'b1;
                i_stall <= 1'b1;
                repeat (PARK_CYCLES) @(negedge i_clk);
                i_stall <= 1'b0;
            end else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("byte_ring_buffer_with_commit_core: mismatch");
        $finish;
    end

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_wr_en      = 1'b0;
        i_cfg_wr_data    = '0;
        i_valid          = 1'b0;
        i_mode           = MODE_PUT;
        i_data_in        = '0;
        i_first_of_block = 1'b0;
        i_block_length   = '0;
        i_read_count     = '0;
        gap_pct          = 0;
        park_request     = 1'b0;
        ring_span        = 256;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty ring, visibility of staged bytes, drop rules, codes
        gap_pct = 20;
        issue(MODE_STATUS, 8'h00, 1'b0, 9'd0, 6'd0);
        issue(MODE_GET,    8'h00, 1'b0, 9'd0, 6'd5);
        issue(MODE_PEEK,   8'h00, 1'b0, 9'd0, 6'd1);
        issue(MODE_PUT,    8'h00, 1'b1, 9'd3, 6'd0);
        issue(MODE_PUT,    8'hFF, 1'b0, 9'd0, 6'd0);
        issue(MODE_PUT,    8'hA5, 1'b0, 9'd0, 6'd0);
        issue(MODE_GET,    8'h00, 1'b0, 9'd0, 6'd4);   // staged only: nothing to read
        issue(MODE_COMMIT, 8'h00, 1'b0, 9'd0, 6'd0);
        issue(MODE_PEEK,   8'h00, 1'b0, 9'd0, 6'd2);
        issue(MODE_GET,    8'h00, 1'b0, 9'd0, 6'd63);  // count saturates
        issue(MODE_PUT,    8'h5A, 1'b1, 9'd256, 6'd0); // free equals length: dropped
        issue(MODE_PUT,    8'h3C, 1'b0, 9'd0, 6'd0);   // rest of dropped block
        issue(MODE_COMMIT, 8'h00, 1'b0, 9'd0, 6'd0);
        issue(MODE_PUT,    8'h81, 1'b1, 9'd255, 6'd0);
        issue(MODE_PUT,    8'h42, 1'b1, 9'h1FF, 6'h3F);
        issue(MODE_GET,    8'h00, 1'b0, 9'd0, 6'd0);
        for (int m = MODE_STATUS + 1; m <= MODE_LAST; m++)
            issue(MODE_W'(m), 8'hFF, 1'b1, 9'h1FF, 6'h3F);
        issue(MODE_PUT,    8'h7E, 1'b1, 9'd0, 6'd0);
        issue(MODE_COMMIT, 8'h00, 1'b0, 9'd0, 6'd0);
        issue(MODE_GET,    8'h00, 1'b0, 9'd0, 6'd32);
        issue(MODE_PEEK,   8'h00, 1'b0, 9'd0, 6'd1);

        // random phases over a spread of ring sizes, out-of-range ones too
        phase_sizes = '{2, 0, 1, 4, 511, 256, 300, 9, 0, 0};
        phase_sizes[8] = $urandom_range(2, 256);
        phase_sizes[9] = $urandom_range(2, 40);
        for (int ph = 0; ph < 10; ph++) begin
            set_ring_size(phase_sizes[ph]);
            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 15;
                default: gap_pct = 40;
            endcase
            if (ph == 0) begin
                // staged pointer laps the read pointer in a two-byte ring
                put_block(5, 1);
                issue(MODE_COMMIT, 8'h00, 1'b0, 9'd0, 6'd0);
                issue(MODE_GET, 8'h00, 1'b0, 9'd0, 6'd32);
            end
            if (ph == 5) park_request = 1'b1;
            run_random(18);
        end

        // closing stretch without idling
        set_ring_size($urandom_range(2, 256));
        gap_pct = 0;
        run_random(40);

        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && replies_due == 0) begin
            $display("byte_ring_buffer_with_commit_core: match");
        end else begin
            $display("byte_ring_buffer_with_commit_core: mismatch");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/brb_pkg.sv
rtl/brb_ram.sv
rtl/brb_front.sv
rtl/brb_back.sv
rtl/byte_ring_buffer_with_commit_core.sv
tb/brb_ring_checker.sv
tb/byte_ring_buffer_with_commit_core_test.sv
